@@ hdl/mmrlp_pkg.sv @@
// Shared types, codes and constants for the multi-mode run-length packer.
package mmrlp_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int REC_BYTES   = 5;
    localparam int RUN_SLOTS   = 4;

    typedef enum logic [2:0] {
        MODE_RAW   = 3'd0,
        MODE_RLE88 = 3'd1,
        MODE_RLE48 = 3'd2,
        MODE_RLE28 = 3'd3,
        MODE_RLE44 = 3'd4,
        MODE_RLE26 = 3'd5,
        MODE_HALF  = 3'd6,
        MODE_ZERO  = 3'd7
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE      = 2'd0,
        CFG_OFFSET    = 2'd1,
        CFG_DIFF_PREV = 2'd2,
        CFG_UNUSED    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] prev_byte;
        logic       end_of_element;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] offset;
        logic       diff_prev;
    } t_cfg;

    // One packed group as it leaves the front: up to five bytes, sent in order.
    typedef struct packed {
        logic [REC_BYTES-1:0][7:0] bytes;
        logic [2:0]                len;
        logic                      last;
    } t_rec;

    typedef logic [RUN_SLOTS-1:0][7:0] t_run_bytes;
    typedef logic [RUN_SLOTS-1:0][8:0] t_run_cnts;

endpackage

@@ hdl/mmrlp_front.sv @@
// Front end: forms the value, tracks runs and builds one packed group record per flush.
module mmrlp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mmrlp_pkg::t_cfg    i_cfg,
    input  logic               i_clear,
    input  logic               i_valid,
    output logic               o_ready,
    input  mmrlp_pkg::t_in     i_data,
    input  logic               i_q_full,
    output logic               o_q_push,
    output mmrlp_pkg::t_rec    o_q_rec
);

    function automatic mmrlp_pkg::t_rec build_rec(
        input mmrlp_pkg::t_mode      m,
        input mmrlp_pkg::t_run_bytes b,
        input mmrlp_pkg::t_run_cnts  c,
        input logic [1:0]            slot,
        input logic                  last
    );
        mmrlp_pkg::t_rec r;
        r      = '0;
        r.last = last;
        case (m)
            mmrlp_pkg::MODE_RLE44: begin
                r.len      = 3'd1;
                r.bytes[0] = {b[0][3:0], c[0][3:0]};
            end
            mmrlp_pkg::MODE_RLE26: begin
                r.len      = 3'd1;
                r.bytes[0] = {b[0][5:0], c[0][1:0]};
            end
            mmrlp_pkg::MODE_RLE88: begin
                r.len      = 3'd2;
                r.bytes[0] = c[0][7:0];
                r.bytes[1] = b[0];
            end
            mmrlp_pkg::MODE_RLE48: begin
                r.len      = (slot == 2'd0) ? 3'd2 : 3'd3;
                r.bytes[0] = {((slot == 2'd0) ? 4'h0 : c[1][3:0]), c[0][3:0]};
                r.bytes[1] = b[0];
                r.bytes[2] = b[1];
            end
            default: begin
                r.len = {1'b0, slot} + 3'd2;
                for (int k = 0; k < mmrlp_pkg::RUN_SLOTS; k++) begin
                    if (k <= int'(slot)) begin
                        r.bytes[0][2*k +: 2] = c[k][1:0];
                    end
                    r.bytes[k+1] = b[k];
                end
            end
        endcase
        return r;
    endfunction

    mmrlp_pkg::t_run_bytes r_bytes, n_bytes;
    mmrlp_pkg::t_run_cnts  r_cnts, n_cnts;
    logic [1:0]            r_slot, n_slot;
    logic                  r_open, n_open;
    logic                  r_half_v, n_half_v;
    logic [3:0]            r_half_nib, n_half_nib;
    mmrlp_pkg::t_rec       r_hold, n_hold;
    logic                  r_hold_v, n_hold_v;

    logic            accept;
    logic [7:0]      v;
    logic [8:0]      maxrun;
    logic            group_end;
    logic            push_a, push_b;
    mmrlp_pkg::t_rec rec_a, rec_b;

    assign o_ready = !r_hold_v && !i_q_full;
    assign accept  = i_valid && o_ready;
    assign v = i_data.data_byte - i_cfg.offset
             - (i_cfg.diff_prev ? i_data.prev_byte : 8'd0);

    always_comb begin
        case (i_cfg.mode)
            mmrlp_pkg::MODE_RLE88: begin maxrun = 9'd256; group_end = 1'b1;            end
            mmrlp_pkg::MODE_RLE48: begin maxrun = 9'd16;  group_end = (r_slot >= 2'd1); end
            mmrlp_pkg::MODE_RLE28: begin maxrun = 9'd4;   group_end = (r_slot == 2'd3); end
            mmrlp_pkg::MODE_RLE44: begin maxrun = 9'd16;  group_end = 1'b1;            end
            default:               begin maxrun = 9'd4;   group_end = 1'b1;            end
        endcase
    end

    always_comb begin
        n_bytes    = r_bytes;
        n_cnts     = r_cnts;
        n_slot     = r_slot;
        n_open     = r_open;
        n_half_v   = r_half_v;
        n_half_nib = r_half_nib;
        push_a     = 1'b0;
        push_b     = 1'b0;
        rec_a      = '0;
        rec_b      = '0;
        if (accept) begin
            case (i_cfg.mode)
                mmrlp_pkg::MODE_RAW: begin
                    push_a         = 1'b1;
                    rec_a.len      = 3'd1;
                    rec_a.bytes[0] = v;
                    rec_a.last     = i_data.end_of_element;
                end
                mmrlp_pkg::MODE_ZERO: begin
                end
                mmrlp_pkg::MODE_HALF: begin
                    if (r_half_v) begin
                        push_a         = 1'b1;
                        rec_a.len      = 3'd1;
                        rec_a.bytes[0] = {v[3:0], r_half_nib};
                        rec_a.last     = i_data.end_of_element;
                        n_half_v       = 1'b0;
                        n_half_nib     = 4'h0;
                    end else if (i_data.end_of_element) begin
                        push_a         = 1'b1;
                        rec_a.len      = 3'd1;
                        rec_a.bytes[0] = {4'h0, v[3:0]};
                        rec_a.last     = 1'b1;
                    end else begin
                        n_half_v   = 1'b1;
                        n_half_nib = v[3:0];
                    end
                end
                default: begin
                    if (!r_open) begin
                        n_slot     = 2'd0;
                        n_bytes[0] = v;
                        n_cnts[0]  = 9'd1;
                        n_open     = 1'b1;
                    end else if (r_cnts[r_slot] >= maxrun || r_bytes[r_slot] != v) begin
                        if (group_end) begin
                            push_a = 1'b1;
                            rec_a  = build_rec(i_cfg.mode, r_bytes, r_cnts, r_slot, 1'b0);
                            n_slot = 2'd0;
                        end else begin
                            n_slot = r_slot + 2'd1;
                        end
                        n_bytes[n_slot] = v;
                        n_cnts[n_slot]  = 9'd1;
                    end else begin
                        n_cnts[r_slot] = r_cnts[r_slot] + 9'd1;
                    end
                    if (i_data.end_of_element) begin
                        push_b = 1'b1;
                        rec_b  = build_rec(i_cfg.mode, n_bytes, n_cnts, n_slot, 1'b1);
                        n_bytes = '0;
                        n_cnts  = '0;
                        n_slot  = 2'd0;
                        n_open  = 1'b0;
                    end
                end
            endcase
        end
    end

    // A second group from the same item waits in the hold register until the queue can take it.
    always_comb begin
        n_hold   = r_hold;
        n_hold_v = r_hold_v;
        o_q_push = 1'b0;
        o_q_rec  = rec_a;
        if (r_hold_v) begin
            o_q_rec = r_hold;
            if (!i_q_full) begin
                o_q_push = 1'b1;
                n_hold_v = 1'b0;
            end
        end else if (push_a) begin
            o_q_push = 1'b1;
            if (push_b) begin
                n_hold   = rec_b;
                n_hold_v = 1'b1;
            end
        end else if (push_b) begin
            o_q_push = 1'b1;
            o_q_rec  = rec_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_bytes    <= '0;
            r_cnts     <= '0;
            r_slot     <= '0;
            r_open     <= 1'b0;
            r_half_v   <= 1'b0;
            r_half_nib <= '0;
            r_hold_v   <= 1'b0;
        end else begin
            r_bytes    <= n_bytes;
            r_cnts     <= n_cnts;
            r_slot     <= n_slot;
            r_open     <= n_open;
            r_half_v   <= n_half_v;
            r_half_nib <= n_half_nib;
            r_hold_v   <= n_hold_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
    end

endmodule

@@ hdl/mmrlp_fifo.sv @@
// Short queue of group records between the front and the back end.
module mmrlp_fifo #(
    parameter int DEPTH = mmrlp_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mmrlp_pkg::t_rec i_rec,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output mmrlp_pkg::t_rec o_rec
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mmrlp_pkg::t_rec  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_cnt;

    logic do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rec   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] inc_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= inc_ptr(r_wptr);
            end
            if (do_pop) begin
                r_rptr <= inc_ptr(r_rptr);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_rec;
        end
    end

endmodule

@@ hdl/mmrlp_back.sv @@
// Back end: sends the bytes of each group record one per transaction.
module mmrlp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rec_valid,
    input  mmrlp_pkg::t_rec i_rec,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output mmrlp_pkg::t_out o_data
);

    mmrlp_pkg::t_rec r_cur;
    logic            r_cur_v;
    logic [2:0]      r_idx;

    logic take, done, load;

    assign o_valid = r_cur_v;
    assign take    = r_cur_v && i_ready;
    assign done    = (r_idx == r_cur.len - 3'd1);
    assign load    = i_rec_valid && (!r_cur_v || (take && done));
    assign o_pop   = load;

    always_comb begin
        o_data.out_byte = r_cur.bytes[0];
        for (int k = 1; k < mmrlp_pkg::REC_BYTES; k++) begin
            if (r_idx == 3'(k)) begin
                o_data.out_byte = r_cur.bytes[k];
            end
        end
        o_data.out_last = r_cur.last && done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_v <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_cur_v <= 1'b1;
            r_idx   <= '0;
        end else if (take) begin
            if (done) begin
                r_cur_v <= 1'b0;
                r_idx   <= '0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur <= i_rec;
        end
    end

endmodule

@@ hdl/multi_mode_run_length_packer.sv @@
// Top level of the multi-mode run-length packer with its configuration registers.
// The packer takes one element byte per transaction, subtracts the offset and
// optionally the previous-frame byte, and packs the result in the selected mode
// (raw, five run-length variants, nibble packing, or an empty body). The front
// end accepts one item per cycle unless the group queue is full or the hold
// register keeps an item's second group. The output port sends one packed byte
// per cycle while the receiver is ready, so the output side sets the sustained
// rate: an item produces 0 to 7 bytes, and the group queue of QUEUE_DEPTH
// records absorbs bursts. Writing the mode register abandons the element in
// progress; registers are to be written while the block is idle.
module multi_mode_run_length_packer #(
    parameter int QUEUE_DEPTH = mmrlp_pkg::QUEUE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mmrlp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mmrlp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  mmrlp_pkg::t_in                      i_data,
    output logic                                o_valid,
    input  logic                                i_ready,
    output mmrlp_pkg::t_out                     o_data
);

    mmrlp_pkg::t_cfg r_cfg;
    logic            cfg_wr;
    logic            mode_wr;

    logic            q_push, q_full, q_pop, q_valid;
    mmrlp_pkg::t_rec q_in, q_out;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;
    assign mode_wr     = cfg_wr && (i_cfg_index == mmrlp_pkg::CFG_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode      <= mmrlp_pkg::MODE_RAW;
            r_cfg.offset    <= '0;
            r_cfg.diff_prev <= 1'b0;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                mmrlp_pkg::CFG_MODE:      r_cfg.mode      <= mmrlp_pkg::t_mode'(i_cfg_data[2:0]);
                mmrlp_pkg::CFG_OFFSET:    r_cfg.offset    <= i_cfg_data[7:0];
                mmrlp_pkg::CFG_DIFF_PREV: r_cfg.diff_prev <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    mmrlp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_clear  (mode_wr),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_data   (i_data),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_rec  (q_in)
    );

    mmrlp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rec   (q_out)
    );

    mmrlp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (q_valid),
        .i_rec       (q_out),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

@@ verif/tb_multi_mode_run_length_packer.sv @@
// Self-checking testbench for the multi-mode run-length packer, with its scoreboard.
`timescale 1ns / 1ps

class packer_scoreboard;
    mmrlp_pkg::t_out  expected_bytes[$];
    int               errors;
    mmrlp_pkg::t_mode mode;
    logic [7:0]       offset;
    logic             diff_prev;
    logic [7:0]       run_val[4];
    logic [8:0]       run_len[4];
    int               slot;
    bit               elem_open;
    bit               half_pending;
    logic [3:0]       half_nibble;

    function new();
        errors    = 0;
        mode      = mmrlp_pkg::MODE_RAW;
        offset    = 8'h00;
        diff_prev = 1'b0;
        clear_element();
    endfunction

    function void clear_element();
        for (int k = 0; k < 4; k++) begin
            run_val[k] = 8'h00;
            run_len[k] = 9'h000;
        end
        slot         = 0;
        elem_open    = 1'b0;
        half_pending = 1'b0;
        half_nibble  = 4'h0;
    endfunction

    function int pending();
        return expected_bytes.size();
    endfunction

    function void emit(logic [7:0] b, logic last);
        mmrlp_pkg::t_out r;
        r.out_byte = b;
        r.out_last = last;
        expected_bytes.push_back(r);
    endfunction

    function void write_register(logic [mmrlp_pkg::CFG_IDX_W-1:0] idx, logic [7:0] value);
        case (idx)
            mmrlp_pkg::CFG_MODE: begin
                // A mode write drops whatever element was being built.
                mode = mmrlp_pkg::t_mode'(value[2:0]);
                clear_element();
            end
            mmrlp_pkg::CFG_OFFSET:    offset = value;
            mmrlp_pkg::CFG_DIFF_PREV: diff_prev = value[0];
            default: ;
        endcase
    endfunction

    // Emits the runs gathered so far as one group.
    function void flush_group(logic last);
        int         runs;
        logic [7:0] hdr;
        runs = slot + 1;
        hdr  = 8'h00;
        case (mode)
            mmrlp_pkg::MODE_RLE88: begin
                emit(run_len[0][7:0], 1'b0);
                emit(run_val[0], last);
            end
            mmrlp_pkg::MODE_RLE44: emit({run_val[0][3:0], run_len[0][3:0]}, last);
            mmrlp_pkg::MODE_RLE26: emit({run_val[0][5:0], run_len[0][1:0]}, last);
            default: begin
                if (mode == mmrlp_pkg::MODE_RLE48) begin
                    if (runs > 2) runs = 2;
                    for (int k = 0; k < runs; k++)
                        hdr = hdr | (8'(run_len[k][3:0]) << (4 * k));
                end else begin
                    for (int k = 0; k < runs; k++)
                        hdr = hdr | (8'(run_len[k][1:0]) << (2 * k));
                end
                // Count bits of runs that never started stay zero.
                emit(hdr, 1'b0);
                for (int k = 0; k < runs; k++)
                    emit(run_val[k], (k == runs - 1) ? last : 1'b0);
            end
        endcase
    endfunction

    function void take_item(mmrlp_pkg::t_in item);
        logic [7:0] v;
        int         group_runs;
        int         max_run;
        int         cur;
        v = item.data_byte - offset;
        if (diff_prev) v = v - item.prev_byte;
        case (mode)
            mmrlp_pkg::MODE_RAW:  emit(v, item.end_of_element);
            mmrlp_pkg::MODE_ZERO: ;
            mmrlp_pkg::MODE_HALF: begin
                if (half_pending) begin
                    emit({v[3:0], half_nibble}, item.end_of_element);
                    half_pending = 1'b0;
                    half_nibble  = 4'h0;
                end else if (item.end_of_element) begin
                    emit({4'h0, v[3:0]}, 1'b1);
                end else begin
                    half_pending = 1'b1;
                    half_nibble  = v[3:0];
                end
            end
            default: begin
                case (mode)
                    mmrlp_pkg::MODE_RLE88: begin group_runs = 1; max_run = 256; end
                    mmrlp_pkg::MODE_RLE48: begin group_runs = 2; max_run = 16;  end
                    mmrlp_pkg::MODE_RLE28: begin group_runs = 4; max_run = 4;   end
                    mmrlp_pkg::MODE_RLE44: begin group_runs = 1; max_run = 16;  end
                    default:               begin group_runs = 1; max_run = 4;   end
                endcase
                if (!elem_open) begin
                    slot       = 0;
                    run_val[0] = v;
                    run_len[0] = 9'd1;
                    elem_open  = 1'b1;
                end else begin
                    cur = slot;
                    if (run_len[cur] >= max_run || run_val[cur] != v) begin
                        if (cur + 1 >= group_runs) begin
                            flush_group(1'b0);
                            slot = 0;
                        end else begin
                            slot = cur + 1;
                        end
                        run_val[slot] = v;
                        run_len[slot] = 9'd1;
                    end else begin
                        run_len[cur] = run_len[cur] + 9'd1;
                    end
                end
                if (item.end_of_element) begin
                    flush_group(1'b1);
                    clear_element();
                end
            end
        endcase
    endfunction

    function void check_byte(mmrlp_pkg::t_out got);
        mmrlp_pkg::t_out want;
        if (expected_bytes.size() == 0) begin
            errors++;
            $error("out_byte %02h (out_last %0b) arrived with nothing expected",
                   got.out_byte, got.out_last);
            return;
        end
        want = expected_bytes.pop_front();
        if (got.out_byte !== want.out_byte) begin
            errors++;
            $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
        end
        if (got.out_last !== want.out_last) begin
            errors++;
            $error("out_last: expected %0b, got %0b", want.out_last, got.out_last);
        end
    endfunction
endclass

module tb_multi_mode_run_length_packer;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 270;

    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [mmrlp_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [mmrlp_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                             i_valid     = 1'b0;
    logic                             o_ready;
    mmrlp_pkg::t_in                   i_data      = '0;
    logic                             o_valid;
    logic                             i_ready     = 1'b0;
    mmrlp_pkg::t_out                  o_data;

    packer_scoreboard sb;

    int burst_left  = 0;
    int ready_style = 0;
    int ready_left  = 0;
    int stall_left  = 0;
    int idle_cycles = 0;

    multi_mode_run_length_packer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

    always #2 i_clk = ~i_clk;

    // Every transaction is seen here, so the drivers never touch the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.write_register(i_cfg_index, i_cfg_data);
            if (i_valid && o_ready) sb.take_item(i_data);
            if (o_valid && i_ready) sb.check_byte(o_data);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // The receiver switches between styles: always ready, coin toss, mostly
    // stalled, and ready with occasional long stalls.
    always @(posedge i_clk) begin
        if (ready_left == 0) begin
            ready_style = $urandom_range(0, 3);
            ready_left  = $urandom_range(16, 96);
        end
        ready_left--;
        case (ready_style)
            0: i_ready <= 1'b1;
            1: i_ready <= 1'($urandom_range(0, 1));
            2: i_ready <= ($urandom_range(0, 3) == 0);
            default: begin
                if (stall_left == 0 && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(3, 12);
                if (stall_left > 0) begin
                    stall_left--;
                    i_ready <= 1'b0;
                end else begin
                    i_ready <= 1'b1;
                end
            end
        endcase
    end

    function automatic mmrlp_pkg::t_in make_item(logic [7:0] data, logic [7:0] prev,
                                                 logic eoe);
        mmrlp_pkg::t_in item;
        item.data_byte      = data;
        item.prev_byte      = prev;
        item.end_of_element = eoe;
        return item;
    endfunction

    function automatic logic [7:0] pick_value(logic [7:0] last_v);
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return last_v ^ 8'h10;
            3:       return last_v ^ 8'h40;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic drive_item(input mmrlp_pkg::t_in item);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_data  <= item;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Drives an item whose packed value comes out as v under the current settings.
    task automatic send_value(input logic [7:0] v, input logic eoe);
        logic [7:0] prev;
        prev = 8'($urandom);
        drive_item(make_item(v + sb.offset + (sb.diff_prev ? prev : 8'h00), prev, eoe));
    endtask

    task automatic send_element(input int len, input int top_run, input bit close);
        int         sent;
        int         run;
        logic [7:0] v;
        sent = 0;
        v    = 8'($urandom);
        while (sent < len) begin
            v   = pick_value(v);
            run = $urandom_range(1, top_run);
            if (run > len - sent) run = len - sent;
            repeat (run) begin
                sent++;
                send_value(v, close && sent == len);
            end
        end
    endtask

    task automatic cfg_write(input mmrlp_pkg::t_cfg_idx idx, input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Unused upper bits of the data carry noise.
    task automatic set_mode(input mmrlp_pkg::t_mode m);
        cfg_write(mmrlp_pkg::CFG_MODE, {5'($urandom), m});
    endtask

    // Holds the sender until every expected byte is back and the block has settled.
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int               phase;
        int               counted;
        int               n_elem;
        int               len;
        int               top_run;
        mmrlp_pkg::t_mode m;

        sb      = new();
        phase   = 0;
        counted = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: raw bytes, field extremes.
        drive_item(make_item(8'h00, 8'hFF, 1'b0));
        drive_item(make_item(8'hFF, 8'h00, 1'b1));
        drive_item(make_item(8'h80, 8'h7F, 1'b1));
        drive_item(make_item(8'h7F, 8'h80, 1'b0));
        wait_idle();
        cfg_write(mmrlp_pkg::CFG_OFFSET, 8'hFF);
        cfg_write(mmrlp_pkg::CFG_DIFF_PREV, 8'h01);
        cfg_write(mmrlp_pkg::CFG_UNUSED, 8'hA5);
        drive_item(make_item(8'h00, 8'h00, 1'b1));
        drive_item(make_item(8'hFF, 8'hFF, 1'b1));
        wait_idle();
        // One nibble pair, then a lone trailing nibble.
        set_mode(mmrlp_pkg::MODE_HALF);
        send_value(8'h1E, 1'b0);
        send_value(8'hC3, 1'b0);
        send_value(8'hB7, 1'b1);
        wait_idle();
        // Group of four closed early after two runs.
        set_mode(mmrlp_pkg::MODE_RLE28);
        send_value(8'h05, 1'b0);
        send_value(8'h05, 1'b0);
        send_value(8'h07, 1'b1);
        wait_idle();
        set_mode(mmrlp_pkg::MODE_RLE48);
        send_value(8'hFF, 1'b1);
        wait_idle();
        // Same low nibble, yet two separate runs.
        set_mode(mmrlp_pkg::MODE_RLE44);
        send_value(8'h3C, 1'b0);
        send_value(8'h4C, 1'b1);
        wait_idle();
        set_mode(mmrlp_pkg::MODE_RLE26);
        for (int k = 0; k < 5; k++) send_value(8'h2A, k == 4);
        wait_idle();
        // A mode write in the middle of an element abandons it.
        set_mode(mmrlp_pkg::MODE_RLE88);
        send_value(8'h00, 1'b0);
        send_value(8'h11, 1'b0);
        wait_idle();
        set_mode(mmrlp_pkg::MODE_RLE88);
        send_value(8'h22, 1'b1);
        wait_idle();
        set_mode(mmrlp_pkg::MODE_ZERO);
        send_value(8'h99, 1'b0);
        send_value(8'h99, 1'b1);
        wait_idle();

        while (counted < RANDOM_ITEMS) begin
            // The first eight phases visit each mode once; later ones may keep
            // the mode and so carry an open element across the other writes.
            if (phase < 8) begin
                m = mmrlp_pkg::t_mode'(phase);
                set_mode(m);
            end else if ($urandom_range(0, 3) != 0) begin
                m = mmrlp_pkg::t_mode'($urandom_range(0, 7));
                set_mode(m);
            end else begin
                m = sb.mode;
            end
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 3))
                    0:       cfg_write(mmrlp_pkg::CFG_OFFSET, 8'h00);
                    1:       cfg_write(mmrlp_pkg::CFG_OFFSET, 8'hFF);
                    default: cfg_write(mmrlp_pkg::CFG_OFFSET, 8'($urandom));
                endcase
            end
            if ($urandom_range(0, 3) != 0)
                cfg_write(mmrlp_pkg::CFG_DIFF_PREV, {7'($urandom), 1'($urandom_range(0, 1))});

            case (m) inside
                mmrlp_pkg::MODE_RLE88:                        top_run = 20;
                mmrlp_pkg::MODE_RLE48, mmrlp_pkg::MODE_RLE44: top_run = 18;
                mmrlp_pkg::MODE_RLE28, mmrlp_pkg::MODE_RLE26: top_run = 6;
                default:                                      top_run = 3;
            endcase
            n_elem = (m == mmrlp_pkg::MODE_ZERO) ? 2 : $urandom_range(1, 6);
            for (int e = 0; e < n_elem; e++) begin
                if (m == mmrlp_pkg::MODE_ZERO)
                    len = $urandom_range(1, 6);
                else
                    len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 24);
                send_element(len, top_run, (e < n_elem - 1) || ($urandom_range(0, 3) != 0));
                counted += len;
            end
            wait_idle();
            phase++;
        end

        wait_idle();
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
